>>> design/ousst_pkg.sv
// ----------------------------------------------------------------------------
// ousst_pkg
// Shared types and constants for the ordered unique set table.
// ----------------------------------------------------------------------------
package ousst_pkg;

  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_MEMBER = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] element;
    logic [3:0]  position;
  } item_t;

  typedef struct packed {
    logic        was_member;
    logic [31:0] element_out;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ousst_cmd_t;

endpackage

>>> design/ousst_ctrl.sv
// ----------------------------------------------------------------------------
// ousst_ctrl
// Sequencer: captures a word, then runs its execute cycle and strobes done.
// ----------------------------------------------------------------------------
module ousst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  output ousst_pkg::ousst_cmd_t cmd
);
  import ousst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign busy        = (state == S_EXEC);
  assign cmd.capture = start && (state == S_IDLE);
  assign cmd.execute = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.execute;
    end
  end

`ifndef ASSERT_OFF
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("capture not followed by execute");
  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> done && !busy)
    else $error("execute not followed by done");
  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.capture && !cmd.execute == 1'b0)
    else $error("capture while busy");
`endif

endmodule

>>> design/ousst_datapath.sv
// ----------------------------------------------------------------------------
// ousst_datapath
// Entry registers, parallel compare, append and gap-closing shift.
// ----------------------------------------------------------------------------
module ousst_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ousst_pkg::ousst_cmd_t cmd,
  input  ousst_pkg::item_t      item,
  output ousst_pkg::result_t    result
);
  import ousst_pkg::*;

  logic [ELEM_WIDTH-1:0] entries [CAPACITY];
  logic [COUNT_W-1:0]    count;
  item_t                 item_q;
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   match_q;
  logic [CAPACITY-1:0]   shift_en;
  logic                  hit;
  logic                  do_append;
  logic                  do_remove;
  logic [COUNT_W-1:0]    count_next;
  result_t               result_next;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (COUNT_W'(i) < count) && (entries[i] == item.element[ELEM_WIDTH-1:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift_en[i] = |(match_q & CAPACITY'((2 ** (i + 1)) - 1));
    end
  end

  assign hit = |match_q;

  always_comb begin
    do_append   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    result_next = '0;
    case (item_q.op)
      OP_INSERT: begin
        result_next.was_member = hit;
        if (!hit) begin
          if (count < COUNT_W'(CAPACITY)) begin
            do_append  = 1'b1;
            count_next = count + COUNT_W'(1);
          end else begin
            result_next.status = ST_FULL;
          end
        end
      end
      OP_REMOVE: begin
        result_next.was_member = hit;
        if (hit) begin
          do_remove  = 1'b1;
          count_next = count - COUNT_W'(1);
        end
      end
      OP_MEMBER: begin
        result_next.was_member = hit;
      end
      OP_READ: begin
        if (COUNT_W'(item_q.position) < count) begin
          result_next.element_out = 32'(entries[item_q.position[IDX_W-1:0]]);
        end else begin
          result_next.status = ST_RANGE;
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
    result_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q  <= item;
      match_q <= match;
    end
    if (cmd.execute) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.execute && do_remove && shift_en[i] && (i < CAPACITY - 1)) begin
        entries[i] <= entries[(i + 1) % CAPACITY];
      end else if (cmd.execute && do_append && (count[IDX_W-1:0] == IDX_W'(i))) begin
        entries[i] <= item_q.element[ELEM_WIDTH-1:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> $onehot0(match_q))
    else $error("element held more than once");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && (result_next.status == ST_FULL) |=> $stable(count))
    else $error("dropped insert changed count");
`endif

endmodule

>>> design/ordered_unique_set_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_unique_set_table_unit
// Insertion-ordered store of unique words with insert, remove, member, read.
//
// Input channel: a command word (item) is taken at a rising edge where start
// is high and busy is low. The word is captured together with a parallel
// compare of its element against every held entry; busy then stays high for
// one execute cycle in which the append or the gap-closing shift is applied.
// Output channel: the result word is registered on result, marked by done
// high for exactly one cycle in the cycle right after the execute cycle; it
// is taken at the edge that ends that cycle. The receiver cannot stall; the
// next command may be accepted in the cycle done is high.
// Commands do not overlap: the capture/execute pair of the controller around
// the single compare and update step finishes each command before the next is taken.
// Reset: rst (synchronous) empties the store and idles the controller; entry
// contents are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_unique_set_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ousst_pkg::item_t   item,
  output logic               busy,
  output logic               done,
  output ousst_pkg::result_t result
);
  import ousst_pkg::*;

  ousst_cmd_t cmd;

  ousst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ousst_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

>>> verif/set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_table_checker
// Watches the command and result channels of the ordered unique set table,
// keeps its own copy of the held elements, predicts the result word of every
// accepted command and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module set_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  ousst_pkg::item_t   cmd_word,
  input  logic               done,
  input  ousst_pkg::result_t reply,
  output int                 mismatches,
  output int                 outstanding
);
  import ousst_pkg::*;

  logic [31:0] held_words [CAPACITY];
  int          held_size;
  result_t     predicted_results [$];
  result_t     want;
  int          reply_index;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held_size   = 0;
    reply_index = 0;
  end

  task automatic report(string msg);
    $display("[%0t] result %0d: %s", $time, reply_index, msg);
    mismatches++;
  endtask

  function automatic result_t apply_set_op(item_t w);
    result_t r;
    int      slot;
    int      i;
    r    = '0;
    slot = held_size;
    if (w.op == OP_READ) begin
      if (int'(w.position) < held_size) begin
        r.element_out = held_words[w.position];
      end else begin
        r.status = ST_RANGE;
      end
    end else begin
      for (i = held_size - 1; i >= 0; i--) begin
        if (held_words[i] == w.element) slot = i;
      end
      r.was_member = (slot < held_size);
      if (w.op == OP_INSERT && !r.was_member) begin
        if (held_size < CAPACITY) begin
          held_words[held_size] = w.element;
          held_size++;
        end else begin
          r.status = ST_FULL;
        end
      end else if (w.op == OP_REMOVE && r.was_member) begin
        for (i = slot; i + 1 < held_size; i++) begin
          held_words[i] = held_words[i + 1];
        end
        held_size--;
      end
    end
    r.entry_count = 5'(held_size);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_size = 0;
      predicted_results.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (predicted_results.size() == 0) begin
          report("result word with no command pending");
        end else begin
          want = predicted_results.pop_front();
          if (reply.was_member !== want.was_member)
            report($sformatf("was_member got %b want %b", reply.was_member,
                             want.was_member));
          if (reply.element_out !== want.element_out)
            report($sformatf("element_out got %h want %h", reply.element_out,
                             want.element_out));
          if (reply.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d", reply.entry_count,
                             want.entry_count));
          if (reply.status !== want.status)
            report($sformatf("status got %0d want %0d", reply.status, want.status));
        end
        reply_index++;
      end
      if (start && !busy) predicted_results.push_back(apply_set_op(cmd_word));
      outstanding <= predicted_results.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ordered unique set table with directed commands covering the
// corner cases, then phased random traffic that fills, churns and empties
// the store, with random gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import ousst_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int BLOCK_LEN    = 50;
  localparam int POOL_SIZE    = 22;
  localparam int IDLE_LIMIT   = 2000;

  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_EMPTY = 2;

  logic    clk      = 1'b0;
  logic    rst      = 1'b1;
  logic    start    = 1'b0;
  item_t   cmd_word = '0;
  logic    busy;
  logic    done;
  result_t reply;
  int      mismatches;
  int      outstanding;
  int      idle_cycles = 0;

  logic [31:0] value_pool [POOL_SIZE];
  bit          no_gaps;

  always #10 clk = ~clk;

  ordered_unique_set_table_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (cmd_word),
    .busy   (busy),
    .done   (done),
    .result (reply)
  );

  set_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd_word    (cmd_word),
    .done        (done),
    .reply       (reply),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t make_word(logic [1:0] op, logic [31:0] element,
                                      logic [3:0] position);
    item_t w;
    w.op       = op;
    w.element  = element;
    w.position = position;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_word(int mode);
    item_t       w;
    int          r;
    logic [1:0]  op;
    logic [31:0] element;
    w = item_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 12) return w;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  op = (r < 60) ? OP_INSERT : (r < 72) ? OP_REMOVE :
                       (r < 86) ? OP_MEMBER : OP_READ;
      MODE_EMPTY: op = (r < 55) ? OP_REMOVE : (r < 67) ? OP_INSERT :
                       (r < 83) ? OP_MEMBER : OP_READ;
      default:    op = 2'(r % 4);
    endcase
    element = ($urandom_range(0, 99) < 88) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom;
    w.op      = op;
    w.element = element;
    return w;
  endfunction

  // hold start high across back-to-back words; lower it only for a gap
  task automatic send(item_t w, int gap);
    if (gap > 0) begin
      start    <= 1'b0;
      cmd_word <= item_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    int n;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (n = 4; n < POOL_SIZE; n++) value_pool[n] = $urandom;
    no_gaps = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(make_word(OP_READ,   32'h0,          4'd0),  0);
    send(make_word(OP_MEMBER, 32'h0,          4'd15), 0);
    send(make_word(OP_REMOVE, 32'h1234_5678,  4'd0),  1);
    send(make_word(OP_INSERT, 32'h0000_0000,  4'd0),  0);
    send(make_word(OP_INSERT, 32'hFFFF_FFFF,  4'd15), 0);
    send(make_word(OP_INSERT, 32'h0000_0000,  4'd0),  2);
    send(make_word(OP_INSERT, 32'hA5A5_5A5A,  4'd0),  0);
    send(make_word(OP_MEMBER, 32'hFFFF_FFFF,  4'd0),  0);
    send(make_word(OP_MEMBER, 32'h1234_5678,  4'd0),  0);
    send(make_word(OP_READ,   32'hFFFF_FFFF,  4'd0),  0);
    send(make_word(OP_READ,   32'h0,          4'd2),  1);
    send(make_word(OP_READ,   32'h0,          4'd3),  0);
    send(make_word(OP_READ,   32'h0,          4'd15), 0);
    send(make_word(OP_REMOVE, 32'h0000_0000,  4'd0),  0);
    send(make_word(OP_READ,   32'h0,          4'd0),  0);
    send(make_word(OP_READ,   32'h0,          4'd1),  0);
    send(make_word(OP_REMOVE, 32'hFFFF_FFFF,  4'd0),  5);
    send(make_word(OP_REMOVE, 32'hA5A5_5A5A,  4'd0),  0);
    send(make_word(OP_READ,   32'h0,          4'd0),  0);
    drain();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        mode    = (n / BLOCK_LEN) % 3;
        no_gaps = ($urandom_range(0, 3) == 0);
        if ((n / BLOCK_LEN) % 6 == 5) drain();
      end
      send(random_word(mode), pick_gap());
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
